// File: src/mpic_pkg.sv
package mpic_pkg;

   localparam int MAX_DIM = 8;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIM_W = 4;
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int CNT_W = 8;
   localparam int DATA_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 4;

   localparam logic [1:0] VERDICT_IDENTITY = 2'd0;
   localparam logic [1:0] VERDICT_NOT_IDENTITY = 2'd1;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_A = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_B = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_B = 3'd3;

   typedef struct packed {
      logic first;
      logic last;
      logic diag;
   } mpic_tag_type;

   typedef struct packed {
      logic wr_en;
      logic wr_b;
      logic [ADDR_W-1:0] wr_addr;
      logic clear;
      logic issue;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      mpic_tag_type tag;
   } mpic_cmd_type;

   typedef struct packed {
      logic busy;
      logic fail;
   } mpic_status_type;

   function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

// File: src/mpic_datapath.sv
module mpic_datapath
   import mpic_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic [DATA_W-1:0] element,
   input  mpic_cmd_type cmd,
   output mpic_status_type status
);

   logic [DATA_W-1:0] mem_a [DEPTH];
   logic [DATA_W-1:0] mem_b [DEPTH];

   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic s1_valid_ff, s2_valid_ff;
   mpic_tag_type s1_tag_ff, s2_tag_ff;
   logic fail_ff, fail_in;
   logic bad;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.wr_b) begin
         mem_a[cmd.wr_addr] <= element;
      end
      rd_a_ff <= mem_a[cmd.addr_a];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_b) begin
         mem_b[cmd.wr_addr] <= element;
      end
      rd_b_ff <= mem_b[cmd.addr_b];
   end

   // low 32 bits of the product, wrapping
   assign prod_in = rd_a_ff * rd_b_ff;

   always_comb begin
      acc_in = (s2_tag_ff.first ? '0 : acc_ff) + prod_ff;
      bad = s2_tag_ff.diag ? (acc_in != DATA_W'(1)) : (acc_in != '0);
      fail_in = fail_ff;
      if (cmd.clear) begin
         fail_in = 1'b0;
      end else if (s2_valid_ff && s2_tag_ff.last && bad) begin
         fail_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff <= prod_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fail_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         fail_ff <= fail_in;
      end
   end

   assign status.busy = s1_valid_ff | s2_valid_ff;
   assign status.fail = fail_ff;

endmodule

// File: src/mpic_ctrl.sv
module mpic_ctrl
   import mpic_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_verdict,
   input  logic csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  mpic_status_type status,
   output mpic_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic [DIM_W-1:0] rows_a_ff, rows_a_in, cols_a_ff, cols_a_in;
   logic [DIM_W-1:0] rows_b_ff, rows_b_in, cols_b_ff, cols_b_in;
   logic [CNT_W-1:0] load_count_ff, load_count_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_verdict_ff, rsp_verdict_in;

   logic [DIM_W-1:0] ra, ca, rb, cb;
   logic [CNT_W-1:0] total_a, total, lc, lc_b;
   logic [2*DIM_W-1:0] ia_full, ib_full;
   logic mismatch, accept, slot_free, k_end, j_end, i_end;

   always_comb begin
      ra = eff_size(rows_a_ff);
      ca = eff_size(cols_a_ff);
      rb = eff_size(rows_b_ff);
      cb = eff_size(cols_b_ff);
      mismatch = (ca != rb);
      total_a = CNT_W'(ra) * CNT_W'(ca);
      total = total_a + CNT_W'(rb) * CNT_W'(cb);
      lc = (load_count_ff >= total) ? '0 : load_count_ff;
      lc_b = lc - total_a;
      ia_full = (2*DIM_W)'(i_ff) * (2*DIM_W)'(ca) + (2*DIM_W)'(k_ff);
      ib_full = (2*DIM_W)'(k_ff) * (2*DIM_W)'(cb) + (2*DIM_W)'(j_ff);
      k_end = (DIM_W'(k_ff) == ca - DIM_W'(1));
      j_end = (DIM_W'(j_ff) == cb - DIM_W'(1));
      i_end = (DIM_W'(i_ff) == ra - DIM_W'(1));
      slot_free = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_LOAD) && slot_free;
      accept = req_valid && req_ready;
   end

   always_comb begin
      cmd.wr_en = accept && !mismatch;
      cmd.wr_b = (lc >= total_a);
      cmd.wr_addr = cmd.wr_b ? lc_b[ADDR_W-1:0] : lc[ADDR_W-1:0];
      cmd.clear = accept && !mismatch && (lc + CNT_W'(1) == total);
      cmd.issue = (state_ff == ST_RUN);
      cmd.addr_a = ia_full[ADDR_W-1:0];
      cmd.addr_b = ib_full[ADDR_W-1:0];
      cmd.tag.first = (k_ff == '0);
      cmd.tag.last = k_end;
      cmd.tag.diag = (i_ff == j_ff);
   end

   always_comb begin
      state_in = state_ff;
      rows_a_in = rows_a_ff;
      cols_a_in = cols_a_ff;
      rows_b_in = rows_b_ff;
      cols_b_in = cols_b_ff;
      load_count_in = load_count_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (mismatch) begin
                  rsp_valid_in = 1'b1;
                  rsp_verdict_in = VERDICT_MISMATCH;
               end else if (cmd.clear) begin
                  load_count_in = '0;
                  i_in = '0;
                  j_in = '0;
                  k_in = '0;
                  state_in = ST_RUN;
               end else begin
                  load_count_in = lc + CNT_W'(1);
               end
            end
         end
         ST_RUN: begin
            if (!k_end) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               k_in = '0;
               if (!j_end) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (!i_end) begin
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!status.busy && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_verdict_in = status.fail ? VERDICT_NOT_IDENTITY : VERDICT_IDENTITY;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            CSR_ROWS_A: rows_a_in = csr_data;
            CSR_COLS_A: cols_a_in = csr_data;
            CSR_ROWS_B: rows_b_in = csr_data;
            CSR_COLS_B: cols_b_in = csr_data;
            default: ;
         endcase
         if (csr_index <= CSR_COLS_B) begin
            load_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rows_a_ff <= DIM_W'(1);
         cols_a_ff <= DIM_W'(1);
         rows_b_ff <= DIM_W'(1);
         cols_b_ff <= DIM_W'(1);
         load_count_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_verdict_ff <= VERDICT_IDENTITY;
      end else begin
         state_ff <= state_in;
         rows_a_ff <= rows_a_in;
         cols_a_ff <= cols_a_in;
         rows_b_ff <= rows_b_in;
         cols_b_ff <= cols_b_in;
         load_count_ff <= load_count_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_verdict_ff <= rsp_verdict_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

// File: src/matrix_product_identity_check.sv
// Matrix product identity check.
// req_ channel: one signed 32-bit element per transaction, matrix A then
// matrix B, both row-major. rsp_ channel: one 2-bit verdict per pair of
// matrices (0 identity, 1 not identity), or one per transaction with
// verdict 2 while cols_a and rows_b differ.
// csr_ port: write rows_a, cols_a, rows_b, cols_b (indexes 0..3); 0 acts
// as 1, above 8 acts as 8. A write to one of these restarts loading.
// Loading takes one element per cycle while no waiting result holds
// req_ready low. After the last element of B the multiply-accumulate
// unit runs one product term per cycle, and req_ready stays low until
// the verdict appears. The pipeline is memory read, 32x32 multiply,
// accumulate and compare.
// A result waits in the output register while rsp_ready is low; the next
// element is still taken when that register will be free in that cycle.
// Reset (synchronous) sets all sizes to 1 and empties the output register;
// store contents are undefined until loaded.
module matrix_product_identity_check
   import mpic_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [DATA_W-1:0] req_element,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_verdict,
   input  logic csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   mpic_cmd_type cmd;
   mpic_status_type status;

   mpic_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_verdict(rsp_verdict),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .status(status),
      .cmd(cmd)
   );

   mpic_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .element(DATA_W'(req_element)),
      .cmd(cmd),
      .status(status)
   );

`ifndef SYNTHESIS
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_IDENTITY ||
                     rsp_verdict == VERDICT_NOT_IDENTITY ||
                     rsp_verdict == VERDICT_MISMATCH))
      else $error("illegal verdict code");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_ready)
      else $error("input taken while product pipeline busy");

   a_issue_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_ready && !cmd.wr_en)
      else $error("load overlaps product pass");

   a_clear_starts_run: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> cmd.issue)
      else $error("product pass did not start after last element");
`endif

endmodule

// File: sim/matrix_product_identity_check_tb.sv
module matrix_product_identity_check_tb
   import mpic_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_COUNT = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = MAX_DIM * MAX_DIM * MAX_DIM + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_GAP = 40;
   localparam int RANDOM_ITEMS = 420;

   typedef enum logic {STEP_CSR, STEP_ELEMENT} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0] value;
      logic [DATA_W-1:0] element;
      bit typed;
      logic [1:0] verdict;
   } directed_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [DATA_W-1:0] req_element = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_verdict;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [CSR_DATA_W-1:0] dims [0:CSR_COUNT-1];
   logic [DATA_W-1:0] store_a [0:DEPTH-1];
   logic [DATA_W-1:0] store_b [0:DEPTH-1];
   int loaded;

   logic [1:0] pending_verdicts [$];
   logic [1:0] want_verdict;
   directed_step_type directed [$];
   int errors = 0;
   int items_sent = 0;
   int ready_hold = 0;
   bit calm = 1'b0;

   matrix_product_identity_check u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_element(req_element),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_verdict(rsp_verdict),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic int eff_dim(input logic [CSR_DATA_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
   endfunction

   function automatic bit predict_verdict(input logic [DATA_W-1:0] value,
                                          output logic [1:0] verdict);
      int ra, n, rb, cb, total_a, total;
      logic [DATA_W-1:0] acc;
      ra = eff_dim(dims[CSR_ROWS_A]);
      n = eff_dim(dims[CSR_COLS_A]);
      rb = eff_dim(dims[CSR_ROWS_B]);
      cb = eff_dim(dims[CSR_COLS_B]);
      verdict = VERDICT_MISMATCH;
      if (n != rb) return 1'b1;
      total_a = ra * n;
      total = total_a + rb * cb;
      if (loaded >= total) loaded = 0;
      if (loaded < total_a) begin
         store_a[loaded] = value;
      end else begin
         store_b[loaded - total_a] = value;
      end
      loaded++;
      if (loaded < total) return 1'b0;
      loaded = 0;
      verdict = VERDICT_IDENTITY;
      for (int i = 0; i < ra; i++) begin
         for (int j = 0; j < cb; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
               acc += store_a[i * n + k] * store_b[k * cb + j];
            end
            if (acc != ((i == j) ? 32'd1 : 32'd0)) verdict = VERDICT_NOT_IDENTITY;
         end
      end
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 8) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, LONG_GAP);
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 5);
      return $urandom_range(6, MAX_DIM);
   endfunction

   // a code for size d, sometimes an alias: 0 for 1, or any of 8..15 for 8
   function automatic logic [CSR_DATA_W-1:0] size_code(input int d);
      if (d == 1 && $urandom_range(0, 3) == 0) return '0;
      if (d == MAX_DIM) return CSR_DATA_W'($urandom_range(MAX_DIM, 15));
      return CSR_DATA_W'(d);
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      errors++;
   endtask

   task automatic add_step(input step_kind_type kind, input logic [CSR_INDEX_W-1:0] idx,
                           input logic [CSR_DATA_W-1:0] value,
                           input logic [DATA_W-1:0] element,
                           input bit typed, input logic [1:0] verdict);
      directed_step_type s;
      s.kind = kind;
      s.idx = idx;
      s.value = value;
      s.element = element;
      s.typed = typed;
      s.verdict = verdict;
      directed.push_back(s);
   endtask

   task automatic send_element(input logic [DATA_W-1:0] value, input bit typed = 1'b0,
                               input logic [1:0] typed_verdict = VERDICT_IDENTITY);
      int gap;
      logic [1:0] verdict;
      gap = calm ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_element = value;
      do @(posedge clock); while (!req_ready);
      if (predict_verdict(value, verdict)) begin
         pending_verdicts.push_back(typed ? typed_verdict : verdict);
      end
      items_sent++;
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx <= CSR_COLS_B) begin
         dims[idx] = value;
         loaded = 0;
      end
   endtask

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready = 1'b0;
         ready_hold--;
      end else begin
         rsp_ready = 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            flag_mismatch($sformatf("verdict %0d with none pending", rsp_verdict));
         end else begin
            want_verdict = pending_verdicts.pop_front();
            if (rsp_verdict !== want_verdict) begin
               flag_mismatch($sformatf("verdict %0d, predicted %0d", rsp_verdict,
                                       want_verdict));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int ra, n, rb, cb, total, pairs, mode, p, q, i, j, k, idx, start, sel;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] mat_a [0:DEPTH-1];
      logic [DATA_W-1:0] mat_b [0:DEPTH-1];
      logic [CSR_DATA_W-1:0] codes [0:CSR_COUNT-1];
      bit streaming;

      for (i = 0; i < CSR_COUNT; i++) dims[i] = CSR_DATA_W'(1);
      for (i = 0; i < DEPTH; i++) begin
         store_a[i] = '0;
         store_b[i] = '0;
      end
      loaded = 0;

      // 1x1 after reset, wrap extremes, mismatch, small shapes, aliased sizes
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b1, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'h8000_0000, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'h7fff_ffff, 1'b1, VERDICT_NOT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'hffff_ffff, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'hffff_ffff, 1'b1, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd0, 1'b1, VERDICT_NOT_IDENTITY);
      add_step(STEP_CSR, CSR_COLS_A, 4'd2, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd5, 1'b1, VERDICT_MISMATCH);
      add_step(STEP_ELEMENT, '0, '0, 32'h8000_0000, 1'b1, VERDICT_MISMATCH);
      add_step(STEP_CSR, CSR_ROWS_B, 4'd2, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd3, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'hffff_fffe, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_ROWS_A, 4'd2, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_COLS_B, 4'd2, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd5, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'hffff_fffb, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_UNUSED, 4'd0, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_ROWS_A, 4'd0, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_COLS_A, 4'd0, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_ROWS_B, 4'd0, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_COLS_B, 4'd0, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'd1, 1'b1, VERDICT_IDENTITY);
      add_step(STEP_CSR, CSR_ROWS_B, 4'd15, '0, 1'b0, VERDICT_IDENTITY);
      add_step(STEP_ELEMENT, '0, '0, 32'h7fff_ffff, 1'b1, VERDICT_MISMATCH);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      streaming = 1'b0;
      foreach (directed[s]) begin
         if (directed[s].kind == STEP_CSR) begin
            if (streaming) drain_and_settle();
            streaming = 1'b0;
            write_csr(directed[s].idx, directed[s].value);
         end else begin
            streaming = 1'b1;
            send_element(directed[s].element, directed[s].typed, directed[s].verdict);
         end
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         drain_and_settle();
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0) begin
            // sizes unchanged, a partial matrix carries over
            write_csr(CSR_INDEX_W'($urandom_range(CSR_COLS_B + 1, 2**CSR_INDEX_W - 1)),
                      CSR_DATA_W'($urandom));
         end else begin
            sel = $urandom_range(0, 19);
            ra = pick_dim();
            n = pick_dim();
            cb = pick_dim();
            rb = n;
            if (sel == 0) begin
               ra = MAX_DIM;
               n = MAX_DIM;
               rb = MAX_DIM;
               cb = MAX_DIM;
            end else if (sel < 3) begin
               rb = n % MAX_DIM + 1;
            end
            codes[CSR_ROWS_A] = size_code(ra);
            codes[CSR_COLS_A] = size_code(n);
            codes[CSR_ROWS_B] = size_code(rb);
            codes[CSR_COLS_B] = size_code(cb);
            start = $urandom_range(0, CSR_COUNT - 1);
            for (i = 0; i < CSR_COUNT; i++) begin
               write_csr(CSR_INDEX_W'((start + i) % CSR_COUNT), codes[(start + i) % CSR_COUNT]);
            end
            if ($urandom_range(0, 3) == 0) begin
               write_csr(CSR_INDEX_W'($urandom_range(CSR_COLS_B + 1, 2**CSR_INDEX_W - 1)),
                         CSR_DATA_W'($urandom));
            end
         end

         ra = eff_dim(dims[CSR_ROWS_A]);
         n = eff_dim(dims[CSR_COLS_A]);
         rb = eff_dim(dims[CSR_ROWS_B]);
         cb = eff_dim(dims[CSR_COLS_B]);
         if (n != rb) begin
            repeat ($urandom_range(1, 6)) send_element($urandom);
         end else begin
            total = ra * n + n * cb;
            pairs = (total > 40) ? 1 : $urandom_range(1, 3);
            repeat (pairs) begin
               mode = $urandom_range(0, 9);
               p = $urandom_range(0, n - 1);
               q = $urandom_range(0, n - 1);
               if (mode == 9) begin
                  // x*x wraps to zero, so (1+x)(1-x) is still one
                  q = p;
                  x = DATA_W'($urandom_range(0, 255) * 2 + 1) << 16;
               end else if (mode < 2) begin
                  x = DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
               end else begin
                  x = $urandom;
               end
               for (i = 0; i < ra; i++) begin
                  for (k = 0; k < n; k++) begin
                     if (mode >= 5 && mode <= 6) begin
                        mat_a[i * n + k] = DATA_W'($urandom_range(0, 2)) - DATA_W'(1);
                     end else if (mode >= 7 && mode <= 8) begin
                        mat_a[i * n + k] = $urandom;
                     end else begin
                        mat_a[i * n + k] = (i == k) ? 32'd1 : 32'd0;
                        if (i == p && k == q) mat_a[i * n + k] += x;
                     end
                  end
               end
               for (k = 0; k < n; k++) begin
                  for (j = 0; j < cb; j++) begin
                     if (mode >= 5 && mode <= 6) begin
                        mat_b[k * cb + j] = DATA_W'($urandom_range(0, 2)) - DATA_W'(1);
                     end else if (mode >= 7 && mode <= 8) begin
                        mat_b[k * cb + j] = $urandom;
                     end else begin
                        mat_b[k * cb + j] = (k == j) ? 32'd1 : 32'd0;
                        if (k == p && j == q) mat_b[k * cb + j] -= x;
                     end
                  end
               end
               if (mode == 3 || mode == 4) begin
                  if ($urandom_range(0, 1) == 0) begin
                     idx = $urandom_range(0, ra * n - 1);
                     mat_a[idx] ^= DATA_W'(1) << $urandom_range(0, DATA_W - 1);
                  end else begin
                     idx = $urandom_range(0, n * cb - 1);
                     mat_b[idx] += DATA_W'($urandom_range(1, 3));
                  end
               end
               for (i = 0; i < ra * n; i++) send_element(mat_a[i]);
               for (i = 0; i < n * cb; i++) send_element(mat_b[i]);
            end
            if (total > 1 && $urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, total - 1)) send_element($urandom);
            end
         end
      end

      drain_and_settle();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
